// ===== rtl/assert_macros.svh =====
// assertion macros for the date converter checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, quiet during reset
`define JD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, quiet during reset
`define JD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/jdc_pkg.sv =====
package jdc_pkg;

    localparam int DAY_BITS = 32;
    // cycles from an accepted item to the clock edge that takes its result
    localparam int LATENCY  = 7;

    localparam logic [31:0] LAST_JULIAN_DAY = 32'd2299160;
    localparam logic [31:0] GREGORIAN_EPOCH = 32'd1721060;
    localparam logic [17:0] DAYS_400Y       = 18'd146097;
    localparam logic [15:0] DAYS_100Y       = 16'd36524;
    localparam logic [10:0] DAYS_4Y         = 11'd1461;
    localparam logic [8:0]  DAYS_1Y         = 9'd365;
    localparam logic [12:0] BC_BASE         = 13'd4713;
    localparam logic [12:0] AD_BASE         = 13'd4712;

    typedef logic [8:0] t_doy;

    // first day of each month (index 0 = january), by leap flag
    function automatic t_doy month_start(input logic leap, input logic [3:0] m);
        t_doy v;
        case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd365;
        endcase
        if (leap && m >= 4'd2) begin
            v = v + 9'd1;
        end
        return v;
    endfunction

endpackage

// ===== rtl/julian_day_to_calendar_date.sv =====
// julian day number to calendar date, one item per clock, result strobed
// on o_valid once it has passed the register stages below; busy is never
// raised: the pipeline accepts an item every cycle and the receiver cannot
// stall it. the pipeline has seven register stages: 400-year estimate,
// 400-year correction, century split, 4-year estimate, 4-year correction,
// year split, and month lookup. days up to 2299160 use the julian calendar,
// later days the gregorian one; gregorian years are always ad.
module julian_day_to_calendar_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_day_number,
    output logic        o_valid,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month_number,
    output logic [23:0] o_year_number,
    output logic        o_before_christ
);
    assign busy = 1'b0;

    // stage 1: select calendar, divide by 400-year cycle (gregorian) or
    // pass the count (julian, treated as one big century of 4-year cycles)
    logic [31:0] w_n;
    logic        w_jul;
    logic [31:0] w_g;
    logic [31:0] w_q400;
    logic [17:0] w_r400;

    assign w_n   = i_day_number[jdc_pkg::DAY_BITS-1:0];
    assign w_jul = (w_n <= jdc_pkg::LAST_JULIAN_DAY);
    assign w_g   = w_n - jdc_pkg::GREGORIAN_EPOCH;

    jdc_divider u_div400 (
        .i_clk   (i_clk),
        .i_num   (w_g),
        .i_den   (jdc_pkg::DAYS_400Y),
        .i_recip (32'd29398),
        .o_quo   (w_q400),
        .o_rem   (w_r400)
    );

    // side data is registered beside the divider estimate
    logic        r1a_v, r1a_jul;
    logic [31:0] r1a_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1a_v <= 1'b0;
        end else begin
            r1a_v <= start;
        end
        r1a_jul <= w_jul;
        r1a_n   <= w_n;
    end

    logic        r1_v, r1_jul;
    logic [31:0] r1_n;
    logic [31:0] r1_q400;
    logic [17:0] r1_r400;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= r1a_v;
        end
        r1_jul  <= r1a_jul;
        r1_n    <= r1a_n;
        r1_q400 <= w_q400;
        r1_r400 <= w_r400;
    end

    // stage 2: century split; value to split in 4-year cycles, plus mode
    // mode: 0 leap-first cycles, 1 plain first four years of a century
    logic [31:0] w_year400;
    logic [1:0]  w_cq;
    logic [15:0] w_rc;

    assign w_year400 = r1_q400 * 32'd400;

    always_comb begin
        w_cq = 2'd0;
        w_rc = 16'd0;
        if (r1_r400 > {2'd0, jdc_pkg::DAYS_100Y}) begin
            if (r1_r400 - 18'd1 >= 18'd3 * {2'd0, jdc_pkg::DAYS_100Y}) begin
                w_cq = 2'd3;
                w_rc = 16'(r1_r400 - 18'd1 - 18'd3 * {2'd0, jdc_pkg::DAYS_100Y});
            end else if (r1_r400 - 18'd1 >= 18'd2 * {2'd0, jdc_pkg::DAYS_100Y}) begin
                w_cq = 2'd2;
                w_rc = 16'(r1_r400 - 18'd1 - 18'd2 * {2'd0, jdc_pkg::DAYS_100Y});
            end else begin
                w_cq = 2'd1;
                w_rc = 16'(r1_r400 - 18'd1 - {2'd0, jdc_pkg::DAYS_100Y});
            end
        end
    end

    logic        r2_v, r2_jul, r2_plain;
    logic [31:0] r2_num;
    logic [31:0] r2_year;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_jul <= r1_jul;
        if (r1_jul) begin
            r2_num   <= r1_n;
            r2_plain <= 1'b0;
            r2_year  <= 32'd0;
        end else if (w_cq == 2'd0) begin
            r2_num   <= {14'd0, r1_r400};
            r2_plain <= 1'b0;
            r2_year  <= w_year400;
        end else if (w_rc < {5'd0, jdc_pkg::DAYS_4Y} - 16'd1) begin
            r2_num   <= {16'd0, w_rc};
            r2_plain <= 1'b1;
            r2_year  <= w_year400 + 32'(w_cq) * 32'd100;
        end else begin
            r2_num   <= {16'd0, w_rc} + 32'd1;
            r2_plain <= 1'b0;
            r2_year  <= w_year400 + 32'(w_cq) * 32'd100;
        end
    end

    // stage 3: 4-year cycle split
    logic [31:0] w_q4;
    logic [17:0] w_r4;

    jdc_divider u_div4 (
        .i_clk   (i_clk),
        .i_num   (r2_num),
        .i_den   ({7'd0, jdc_pkg::DAYS_4Y}),
        .i_recip (32'd2939744),
        .o_quo   (w_q4),
        .o_rem   (w_r4)
    );

    // side data is registered beside the divider estimate
    logic        r3a_v, r3a_jul, r3a_plain;
    logic [10:0] r3a_num;
    logic [31:0] r3a_year;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3a_v <= 1'b0;
        end else begin
            r3a_v <= r2_v;
        end
        r3a_jul   <= r2_jul;
        r3a_plain <= r2_plain;
        r3a_num   <= r2_num[10:0];
        r3a_year  <= r2_year;
    end

    logic        r3_v, r3_jul, r3_plain;
    logic [31:0] r3_year;
    logic [10:0] r3_r4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r3a_v;
        end
        r3_jul   <= r3a_jul;
        r3_plain <= r3a_plain;
        r3_r4    <= r3a_plain ? r3a_num : w_r4[10:0];
        r3_year  <= r3a_plain ? r3a_year : r3a_year + {w_q4[29:0], 2'b00};
    end

    // stage 4: year within the cycle, era
    logic [1:0]  w_yoff;
    logic [8:0]  w_doy;
    logic        w_leap;
    logic [10:0] w_t;
    logic [31:0] w_year;

    always_comb begin
        w_t = r3_plain ? r3_r4 : r3_r4 - 11'd1;
        if (!r3_plain && r3_r4 <= 11'd365) begin
            w_yoff = 2'd0;
            w_doy  = r3_r4[8:0];
            w_leap = 1'b1;
        end else if (w_t >= 11'd1095) begin
            w_yoff = 2'd3;
            w_doy  = 9'(w_t - 11'd1095);
            w_leap = 1'b0;
        end else if (w_t >= 11'd730) begin
            w_yoff = 2'd2;
            w_doy  = 9'(w_t - 11'd730);
            w_leap = 1'b0;
        end else if (w_t >= 11'd365) begin
            w_yoff = 2'd1;
            w_doy  = 9'(w_t - 11'd365);
            w_leap = 1'b0;
        end else begin
            w_yoff = 2'd0;
            w_doy  = w_t[8:0];
            w_leap = 1'b0;
        end
        w_year = r3_year + {30'd0, w_yoff};
    end

    logic        r4_v, r4_leap, r4_bc;
    logic [8:0]  r4_doy;
    logic [23:0] r4_year;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_leap <= w_leap;
        r4_doy  <= w_doy;
        if (r3_jul && w_year < {19'd0, jdc_pkg::BC_BASE}) begin
            r4_bc   <= 1'b1;
            r4_year <= 24'({19'd0, jdc_pkg::BC_BASE} - w_year);
        end else if (r3_jul) begin
            r4_bc   <= 1'b0;
            r4_year <= 24'(w_year - {19'd0, jdc_pkg::AD_BASE});
        end else begin
            r4_bc   <= 1'b0;
            r4_year <= w_year[23:0];
        end
    end

    // stage 5: month by parallel compare against month starts
    logic [3:0] w_m;
    logic [8:0] w_day;

    always_comb begin
        w_m = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (r4_doy >= jdc_pkg::month_start(r4_leap, 4'(k))) begin
                w_m = 4'(k);
            end
        end
        w_day = r4_doy - jdc_pkg::month_start(r4_leap, w_m) + 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r4_v;
        end
        o_day_of_month  <= w_day[4:0];
        o_month_number  <= w_m + 4'd1;
        o_year_number   <= r4_year;
        o_before_christ <= r4_bc;
    end
endmodule

// ===== rtl/jdc_divider.sv =====
// constant divider: quotient and remainder of a 32-bit value by a constant
// below 2^18, quotient through a reciprocal multiply plus one correction
// estimate is registered, correction is combinational after it
module jdc_divider (
    input  logic        i_clk,
    input  logic [31:0] i_num,
    input  logic [17:0] i_den,
    input  logic [31:0] i_recip,
    output logic [31:0] o_quo,
    output logic [17:0] o_rem
);
    // recip = floor(2^32 / den); estimate is q or q-1
    logic [63:0] w_prod;
    logic [31:0] r_q;
    logic [31:0] r_num;
    logic [49:0] w_qd;
    logic [32:0] w_r;

    assign w_prod = {32'd0, i_num} * {32'd0, i_recip};

    always_ff @(posedge i_clk) begin
        r_q   <= w_prod[63:32];
        r_num <= i_num;
    end

    assign w_qd = {18'd0, r_q} * {32'd0, i_den};
    assign w_r  = {1'b0, r_num} - {1'b0, w_qd[31:0]};

    always_comb begin
        if (w_r >= {15'd0, i_den}) begin
            o_quo = r_q + 32'd1;
            o_rem = 18'(w_r - {15'd0, i_den});
        end else begin
            o_quo = r_q;
            o_rem = w_r[17:0];
        end
    end
endmodule

// ===== rtl/jdc_checker.sv =====
`include "assert_macros.svh"

module jdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [4:0]  o_day_of_month,
    input logic [3:0]  o_month_number,
    input logic        o_before_christ,
    input logic [23:0] o_year_number
);
    `JD_ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)
    `JD_ASSERT_NEXT(a_latency, i_clk, i_rst_n, start, ##(jdc_pkg::LATENCY - 1) o_valid)
    `JD_ASSERT_IMPL(a_month_range, i_clk, i_rst_n, o_valid, o_month_number >= 4'd1 && o_month_number <= 4'd12)
    `JD_ASSERT_IMPL(a_day_range, i_clk, i_rst_n, o_valid, o_day_of_month >= 5'd1)
    `JD_ASSERT_IMPL(a_year_nonzero, i_clk, i_rst_n, o_valid, o_year_number != 24'd0 || !o_before_christ)
endmodule

bind julian_day_to_calendar_date jdc_checker u_jdc_checker (.*);
